### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/core/gbai_pkg.sv
// Package with opcodes, sequencer states and widths for the body unit.
package gbai_pkg;
  localparam int unsigned OpW = 3;
  localparam int unsigned MassW = 24;
  localparam int unsigned WordW = 32;
  localparam int unsigned FracBits = 16;
  localparam logic [MassW-1:0] MassMax = {MassW{1'b1}};
  localparam logic [WordW-1:0] SoftReset = 32'd484249;

  typedef enum logic [OpW-1:0] {
    OP_LOAD  = 3'd0,
    OP_CLEAR = 3'd1,
    OP_ACCUM = 3'd2,
    OP_INTEG = 3'd3,
    OP_MERGE = 3'd4
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_D2,
    ST_SQRT,
    ST_DEN,
    ST_DENH,
    ST_NUM,
    ST_DIV,
    ST_ACC,
    ST_MOM,
    ST_MDIV,
    ST_MFIN,
    ST_INT2,
    ST_DONE
  } state_t;
endpackage

### rtl/core/gbai_chan_if.sv
// Valid/ready channel interfaces for input items, result items and configuration.
interface gbai_in_if;
  logic valid;
  logic ready;
  logic [2:0] opcode;
  logic signed [31:0] in_x;
  logic signed [31:0] in_y;
  logic signed [31:0] in_vx;
  logic signed [31:0] in_vy;
  logic [23:0] in_mass;
  modport source(output valid, opcode, in_x, in_y, in_vx, in_vy, in_mass, input ready);
  modport sink(input valid, opcode, in_x, in_y, in_vx, in_vy, in_mass, output ready);
endinterface

interface gbai_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x_out;
  logic signed [31:0] pos_y_out;
  logic signed [31:0] vel_x_out;
  logic signed [31:0] vel_y_out;
  logic signed [31:0] acc_x_out;
  logic signed [31:0] acc_y_out;
  logic [23:0] mass_out;
  modport source(output valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
                 acc_x_out, acc_y_out, mass_out, input ready);
  modport sink(input valid, pos_x_out, pos_y_out, vel_x_out, vel_y_out,
               acc_x_out, acc_y_out, mass_out, output ready);
endinterface

interface gbai_cfg_if;
  logic valid;
  logic ready;
  logic [31:0] data;
  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

### rtl/core/gravity_body_accumulate_integrate.sv
// Top level: one 2D body with a bit-by-bit square root and a shared shift-subtract divider.
//
//  channel   dir  fields
//  in_ch     in   opcode, in_x, in_y, in_vx, in_vy, in_mass
//  out_ch    out  pos/vel/acc x,y and mass_out
//  cfg_ch    in   data (softening_sq)
//
// The result is offered once the item has run through its states: load, clear and unused
// opcodes go straight to it, integrate passes through ST_INT2, merge through a quotient per
// axis (none when both masses are zero) and accumulate through the one-bit-per-cycle loops:
// 34 steps for the square root, then the shift-subtract quotient for each axis.
// Reset is synchronous and clears the body and sets softening_sq to its default.
// Input is taken only when idle; a held result stalls the next item until taken.
module gravity_body_accumulate_integrate (
  input logic clk,
  input logic rst,
  gbai_in_if.sink in_ch,
  gbai_out_if.source out_ch,
  gbai_cfg_if.sink cfg_ch
);
  import gbai_pkg::*;

  localparam int DW = 128;
  localparam int DCW = $clog2(DW + 1);
  localparam int D2W = 50;
  localparam int DLO = 25;
  localparam int DPW = D2W - DLO + 34;

  state_t state, state_next;

  // Body state and configuration.
  logic signed [31:0] pos_x, pos_y, vel_x, vel_y, acc_x, acc_y;
  logic [23:0] body_mass;
  logic [31:0] softening_sq;

  // Latched item.
  logic signed [31:0] ivx, ivy;
  logic [23:0] im;

  // Working registers.
  logic [32:0] mag_x, mag_y;
  logic neg_x, neg_y;
  logic [D2W-1:0] d2;
  logic [33:0] root;
  logic [DW-1:0] num, rem, quo, den;
  logic [DCW-1:0] cnt;
  logic axis;
  logic signed [57:0] mom_y;
  logic [24:0] tot;
  logic t_val;

  // Squares of the distance terms and the softened distance squared.
  logic [65:0] sq_x, sq_y;
  logic [D2W-1:0] d2_sum;
  assign sq_x = {33'd0, mag_x} * {33'd0, mag_x};
  assign sq_y = {33'd0, mag_y} * {33'd0, mag_y};
  assign d2_sum = D2W'(sq_x >> FracBits) + D2W'(sq_y >> FracBits)
                  + {{(D2W-32){1'b0}}, softening_sq};

  // Restoring shift-subtract step, shared by the axis division and the merge division.
  logic [DW-1:0] rem_sh, trial;
  logic take;
  assign rem_sh = {rem[DW-2:0], num[DW-1]};
  assign take = rem_sh >= trial;

  // Square root trial: compare d2*2^F against (root|bit)^2 via root bit test.
  logic [33:0] cand;
  logic [67:0] cand_sq;
  logic [DW-1:0] rad;
  assign cand = root | (34'd1 << cnt[5:0]);
  assign cand_sq = {34'd0, cand} * {34'd0, cand};
  assign rad = {{(DW-D2W){1'b0}}, d2} << FracBits;

  // Denominator d2*root built from two partial products, low half in ST_DEN, high in ST_DENH.
  logic [D2W-DLO-1:0] d2_part;
  logic [DPW-1:0] dprod;
  assign d2_part = (state == ST_DENH) ? d2[D2W-1:DLO] : d2[DLO-1:0];
  assign dprod = {34'd0, d2_part} * {{(D2W-DLO){1'b0}}, root};

  always_comb begin
    trial = den;
  end

  // Saturation helper for 33-bit sums.
  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'sd2147483647) return 32'sh7fffffff;
    if (v < -33'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  logic in_fire;
  assign in_ch.ready = (state == ST_IDLE);
  assign in_fire = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = (state == ST_IDLE);
  assign out_ch.valid = (state == ST_DONE);
  assign out_ch.pos_x_out = pos_x;
  assign out_ch.pos_y_out = pos_y;
  assign out_ch.vel_x_out = vel_x;
  assign out_ch.vel_y_out = vel_y;
  assign out_ch.acc_x_out = acc_x;
  assign out_ch.acc_y_out = acc_y;
  assign out_ch.mass_out = body_mass;

  // Quotient saturation to 2^31 and signed result; a positive pull stops at 2^31-1.
  logic [31:0] qsat;
  logic [31:0] qpos;
  logic signed [32:0] pull_v;
  assign qsat = (quo > {{(DW-32){1'b0}}, 32'h80000000}) ? 32'h80000000 : quo[31:0];
  assign qpos = qsat[31] ? 32'h7fffffff : qsat;
  assign pull_v = (axis ? neg_y : neg_x) ? -$signed({1'b0, qsat}) : $signed({1'b0, qpos});

  // Merge momentum of the x axis.
  logic signed [57:0] mom_a;
  logic signed [57:0] mom_x_v;
  assign mom_a = $signed({{26{ivx[31]}}, ivx}) * $signed({33'd0, im});
  assign mom_x_v = $signed({{26{vel_x[31]}}, vel_x}) * $signed({33'd0, body_mass}) + mom_a;

  // Merge quotient sign handling.
  logic signed [57:0] mq;
  assign mq = t_val ? -$signed({1'b0, quo[56:0]}) : $signed({1'b0, quo[56:0]});

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_fire) begin
        unique case (in_ch.opcode)
          OP_ACCUM: state_next = ST_D2;
          OP_MERGE: state_next = ST_MOM;
          OP_INTEG: state_next = ST_INT2;
          default: state_next = ST_DONE;
        endcase
      end
      ST_D2: state_next = ST_SQRT;
      ST_SQRT: if (cnt == '0) state_next = ST_DEN;
      ST_DEN: state_next = ST_DENH;
      ST_DENH: state_next = ST_NUM;
      ST_NUM: state_next = ST_DIV;
      ST_DIV: if (cnt == '0) state_next = ST_ACC;
      ST_ACC: state_next = axis ? ST_DONE : ST_NUM;
      ST_MOM: state_next = (tot == '0) ? ST_MFIN : ST_MDIV;
      ST_MDIV: if (cnt == '0) state_next = ST_MFIN;
      ST_MFIN: state_next = (axis || tot == '0) ? ST_DONE : ST_MDIV;
      ST_INT2: state_next = ST_DONE;
      ST_DONE: if (out_ch.ready) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  // Datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos_x <= '0; pos_y <= '0; vel_x <= '0; vel_y <= '0;
      acc_x <= '0; acc_y <= '0; body_mass <= '0;
      softening_sq <= SoftReset;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) softening_sq <= cfg_ch.data;
      unique case (state)
        ST_IDLE: if (in_fire) begin
          ivx <= in_ch.in_vx; ivy <= in_ch.in_vy; im <= in_ch.in_mass;
          axis <= 1'b0;
          begin
            logic signed [32:0] rx, ry;
            rx = $signed({in_ch.in_x[31], in_ch.in_x}) - $signed({pos_x[31], pos_x});
            ry = $signed({in_ch.in_y[31], in_ch.in_y}) - $signed({pos_y[31], pos_y});
            neg_x <= rx[32]; neg_y <= ry[32];
            mag_x <= rx[32] ? 33'(-rx) : 33'(rx);
            mag_y <= ry[32] ? 33'(-ry) : 33'(ry);
          end
          tot <= {1'b0, body_mass} + {1'b0, in_ch.in_mass};
          unique case (in_ch.opcode)
            OP_LOAD: begin
              pos_x <= in_ch.in_x; pos_y <= in_ch.in_y;
              vel_x <= in_ch.in_vx; vel_y <= in_ch.in_vy;
              acc_x <= '0; acc_y <= '0; body_mass <= in_ch.in_mass;
            end
            OP_CLEAR: begin
              acc_x <= '0; acc_y <= '0;
            end
            OP_INTEG: begin
              vel_x <= sat33($signed({vel_x[31], vel_x}) + $signed({acc_x[31], acc_x}));
              vel_y <= sat33($signed({vel_y[31], vel_y}) + $signed({acc_y[31], acc_y}));
            end
            default: ;
          endcase
        end
        ST_INT2: begin
          pos_x <= sat33($signed({pos_x[31], pos_x}) + $signed({vel_x[31], vel_x}));
          pos_y <= sat33($signed({pos_y[31], pos_y}) + $signed({vel_y[31], vel_y}));
        end
        // A zero distance squared is taken as one.
        ST_D2: begin
          d2 <= (d2_sum == '0) ? D2W'(1) : d2_sum;
          root <= '0;
          cnt <= DCW'(33);
        end
        ST_SQRT: begin
          if (rad >= {{(DW-68){1'b0}}, cand_sq}) root <= cand;
          if (cnt != '0) cnt <= cnt - 1'b1;
        end
        ST_DEN: den <= {{(DW-DPW){1'b0}}, dprod};
        ST_DENH: den <= den + ({{(DW-DPW){1'b0}}, dprod} << DLO);
        ST_NUM: begin
          num <= DW'({33'd0, (axis ? mag_y : mag_x)} * {33'd0, im}) << (2 * FracBits);
          rem <= '0; quo <= '0;
          cnt <= DCW'(DW);
        end
        ST_DIV: begin
          if (cnt != '0) begin
            num <= num << 1;
            quo <= {quo[DW-2:0], take};
            rem <= take ? rem_sh - trial : rem_sh;
            cnt <= cnt - 1'b1;
          end
        end
        ST_ACC: begin
          if (axis) acc_y <= sat33($signed({acc_y[31], acc_y}) + pull_v);
          else acc_x <= sat33($signed({acc_x[31], acc_x}) + pull_v);
          axis <= ~axis;
        end
        ST_MOM: begin
          mom_y <= $signed({{26{vel_y[31]}}, vel_y}) * $signed({33'd0, body_mass})
                   + $signed({{26{ivy[31]}}, ivy}) * $signed({33'd0, im});
          t_val <= mom_x_v[57];
          num <= DW'(mom_x_v[57] ? 58'(-mom_x_v) : 58'(mom_x_v)) << (DW - 58);
          den <= DW'(tot);
          rem <= '0; quo <= '0;
          cnt <= DCW'(58);
          body_mass <= tot[24] ? MassMax : tot[23:0];
        end
        ST_MDIV: begin
          if (cnt != '0) begin
            num <= num << 1;
            quo <= {quo[DW-2:0], take};
            rem <= take ? rem_sh - trial : rem_sh;
            cnt <= cnt - 1'b1;
          end
        end
        ST_MFIN: if (tot != '0) begin
          if (axis) vel_y <= sat33(33'(mq > 58'sd2147483647 ? 58'sd2147483648 :
                                   (mq < -58'sd2147483648 ? -58'sd2147483649 : mq)));
          else begin
            vel_x <= sat33(33'(mq > 58'sd2147483647 ? 58'sd2147483648 :
                               (mq < -58'sd2147483648 ? -58'sd2147483649 : mq)));
            t_val <= mom_y[57];
            num <= DW'(mom_y[57] ? 58'(-mom_y) : 58'(mom_y)) << (DW - 58);
            rem <= '0; quo <= '0;
            cnt <= DCW'(58);
          end
          axis <= ~axis;
        end
        default: ;
      endcase
    end
  end
endmodule

### rtl/core/gbai_checker.sv
// Port-level checker for the body unit, bound to the top level.
`include "assert_macros.svh"
module gbai_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [23:0] mass_out
);
  // No new item is taken while a result is pending.
  `CHK_IMPL(a_no_in_while_out, clk, rst, out_valid, !in_ready)
  // After an item is taken, the input is not ready in the next cycle.
  `CHK_NEXT(a_accept_busy, clk, rst, in_valid && in_ready, !in_ready)
  // A result is shown until taken.
  `CHK_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(mass_out))
endmodule

bind gravity_body_accumulate_integrate gbai_checker u_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready),
  .mass_out(out_ch.mass_out)
);

### test/tb_gravity_body_accumulate_integrate.sv
// Self-checking testbench for the 2D gravity body unit with its own body predictor.
`timescale 1ns / 1ps

module tb_gravity_body_accumulate_integrate;
  import gbai_pkg::*;

  localparam logic [2:0] OpSpareFirst = 3'd5;
  localparam logic [2:0] OpSpareMid = 3'd6;
  localparam logic [2:0] OpSpareLast = 3'd7;
  localparam int RandomItems = 1830;
  localparam int QuietTail = 300;
  localparam longint CycleLimit = 4000000;
  localparam int DrainCycles = 20;
  localparam int LongHold = 3000;

  typedef struct {
    logic [2:0] opcode;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic [23:0] mass;
  } body_item_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] ax;
    logic signed [31:0] ay;
    logic [23:0] mass;
  } body_state_t;

  logic clk;
  logic rst;

  gbai_in_if in_ch();
  gbai_out_if out_ch();
  gbai_cfg_if cfg_ch();

  gravity_body_accumulate_integrate i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // Predicted body and softening term.
  body_state_t body;
  logic [31:0] soft_sq;
  body_state_t expected_states[$];

  int mismatches = 0;
  longint cycles = 0;
  bit idle_on;
  int hold_requests = 0;

  // Clock.
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Run limit.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic logic signed [31:0] clamp32(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic [63:0] isqrt_wide(input logic [127:0] x);
    logic [63:0] res;
    logic [63:0] c;
    res = '0;
    for (int b = 33; b >= 0; b--) begin
      c = res | (64'd1 << b);
      if (x >= {64'd0, c} * {64'd0, c}) res = c;
    end
    return res;
  endfunction

  // One axis of the softened pull, magnitude truncated and clamped at 2^31.
  function automatic longint axis_pull(input longint r, input logic [23:0] m,
                                       input logic [63:0] d2, input logic [63:0] root);
    logic [63:0] mag;
    logic [127:0] num;
    logic [127:0] den;
    logic [127:0] q;
    mag = (r < 0) ? 64'(-r) : 64'(r);
    num = ({104'd0, m} * {64'd0, mag}) << (2 * FracBits);
    den = {64'd0, d2} * {64'd0, root};
    q = num / den;
    if (q > 128'h80000000) q = 128'h80000000;
    if (r < 0) return -longint'(q[63:0]);
    return longint'(clamp32(longint'(q[63:0])));
  endfunction

  function automatic logic signed [31:0] merged_vel(input logic signed [31:0] v,
                                                    input logic signed [31:0] vo,
                                                    input logic [23:0] m,
                                                    input logic [23:0] mo,
                                                    input longint tot);
    longint p;
    p = longint'(v) * longint'({40'd0, m}) + longint'(vo) * longint'({40'd0, mo});
    return clamp32(p / tot);
  endfunction

  // Apply one item to the predicted body.
  task automatic advance_body(input body_item_t it);
    longint rx;
    longint ry;
    logic [63:0] mx;
    logic [63:0] my;
    logic [63:0] d2;
    logic [63:0] root;
    longint tot;
    case (it.opcode)
      OP_LOAD: begin
        body.px = it.x;
        body.py = it.y;
        body.vx = it.vx;
        body.vy = it.vy;
        body.ax = '0;
        body.ay = '0;
        body.mass = it.mass;
      end
      OP_CLEAR: begin
        body.ax = '0;
        body.ay = '0;
      end
      OP_ACCUM: begin
        rx = longint'(it.x) - longint'(body.px);
        ry = longint'(it.y) - longint'(body.py);
        mx = (rx < 0) ? 64'(-rx) : 64'(rx);
        my = (ry < 0) ? 64'(-ry) : 64'(ry);
        d2 = ((mx * mx) >> FracBits) + ((my * my) >> FracBits) + {32'd0, soft_sq};
        if (d2 == 0) d2 = 1;
        root = isqrt_wide({64'd0, d2} << FracBits);
        body.ax = clamp32(longint'(body.ax) + axis_pull(rx, it.mass, d2, root));
        body.ay = clamp32(longint'(body.ay) + axis_pull(ry, it.mass, d2, root));
      end
      OP_INTEG: begin
        body.vx = clamp32(longint'(body.vx) + longint'(body.ax));
        body.vy = clamp32(longint'(body.vy) + longint'(body.ay));
        body.px = clamp32(longint'(body.px) + longint'(body.vx));
        body.py = clamp32(longint'(body.py) + longint'(body.vy));
      end
      OP_MERGE: begin
        tot = longint'({40'd0, body.mass}) + longint'({40'd0, it.mass});
        if (tot != 0) begin
          body.vx = merged_vel(body.vx, it.vx, body.mass, it.mass, tot);
          body.vy = merged_vel(body.vy, it.vy, body.mass, it.mass, tot);
        end
        body.mass = (tot > longint'({40'd0, MassMax})) ? MassMax : tot[23:0];
      end
      default: begin
      end
    endcase
  endtask

  // Send one item and record the body state it should produce.
  task automatic send_item(input body_item_t it);
    @(negedge clk);
    in_ch.valid = 1'b1;
    in_ch.opcode = it.opcode;
    in_ch.in_x = it.x;
    in_ch.in_y = it.y;
    in_ch.in_vx = it.vx;
    in_ch.in_vy = it.vy;
    in_ch.in_mass = it.mass;
    do @(posedge clk); while (!in_ch.ready);
    advance_body(it);
    expected_states.insert(expected_states.size(), body);
  endtask

  task automatic sender_gap(input int n);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_gap();
    if (idle_on && $urandom_range(0, 3) == 0) sender_gap($urandom_range(1, 15));
  endtask

  // Wait until every predicted result has come back.
  task automatic wait_results();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_states.size() != 0) @(negedge clk);
  endtask

  task automatic write_softening(input logic [31:0] value);
    wait_results();
    repeat (5) @(negedge clk);
    cfg_ch.valid = 1'b1;
    cfg_ch.data = value;
    do @(posedge clk); while (!cfg_ch.ready);
    soft_sq = value;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic body_item_t make_item(input logic [2:0] op, input logic [31:0] x,
                                           input logic [31:0] y, input logic [31:0] vx,
                                           input logic [31:0] vy, input logic [23:0] m);
    body_item_t it;
    it.opcode = op;
    it.x = x;
    it.y = y;
    it.vx = vx;
    it.vy = vy;
    it.mass = m;
    return it;
  endfunction

  // Mostly modest magnitudes so orbits stay meaningful, sometimes any word.
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000);
      default: return 32'($signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000);
    endcase
  endfunction

  function automatic logic [23:0] rand_mass();
    case ($urandom_range(0, 3))
      0: return 24'($urandom);
      1: return '0;
      default: return 24'($urandom_range(1, 5000));
    endcase
  endfunction

  function automatic body_item_t rand_item();
    int pick;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if (pick < 10) op = OP_LOAD;
    else if (pick < 18) op = OP_CLEAR;
    else if (pick < 55) op = OP_ACCUM;
    else if (pick < 85) op = OP_INTEG;
    else if (pick < 95) op = OP_MERGE;
    else op = 3'($urandom_range(OpSpareFirst, OpSpareLast));
    return make_item(op, rand_word(), rand_word(), rand_word(), rand_word(), rand_mass());
  endfunction

  // Result sink: random stall bursts, or a long hold when asked.
  initial begin
    int burst;
    int hold_left;
    int hold_served;
    out_ch.ready = 1'b0;
    burst = 0;
    hold_left = 0;
    hold_served = 0;
    forever begin
      @(negedge clk);
      if (hold_served != hold_requests) begin
        hold_served = hold_requests;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        out_ch.ready = 1'b0;
        hold_left = hold_left - 1;
      end else if (burst > 0) begin
        out_ch.ready = 1'b0;
        burst = burst - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        burst = $urandom_range(0, 14);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  // Compare each result with the oldest prediction.
  always @(posedge clk) begin
    body_state_t exp_s;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_states.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("Unexpected result item at cycle %0d", cycles);
      end else begin
        exp_s = expected_states.pop_front();
        if (out_ch.pos_x_out !== exp_s.px || out_ch.pos_y_out !== exp_s.py ||
            out_ch.vel_x_out !== exp_s.vx || out_ch.vel_y_out !== exp_s.vy ||
            out_ch.acc_x_out !== exp_s.ax || out_ch.acc_y_out !== exp_s.ay ||
            out_ch.mass_out !== exp_s.mass) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch at cycle %0d", cycles);
            $display("  pos exp %h %h got %h %h", exp_s.px, exp_s.py,
                     out_ch.pos_x_out, out_ch.pos_y_out);
            $display("  vel exp %h %h got %h %h", exp_s.vx, exp_s.vy,
                     out_ch.vel_x_out, out_ch.vel_y_out);
            $display("  acc exp %h %h got %h %h", exp_s.ax, exp_s.ay,
                     out_ch.acc_x_out, out_ch.acc_y_out);
            $display("  mass exp %h got %h", exp_s.mass, out_ch.mass_out);
          end
        end
      end
    end
  end

  // Extremes of each field, every opcode and the special cases.
  task automatic test_directed_ops();
    send_item(make_item(OP_INTEG, 0, 0, 0, 0, 0));
    send_item(make_item(OP_MERGE, 0, 0, 32'h7fffffff, 32'h80000000, 0));
    send_item(make_item(OP_LOAD, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                        32'h80000000, MassMax));
    send_item(make_item(OP_INTEG, 0, 0, 0, 0, 0));
    send_item(make_item(OP_ACCUM, 32'h80000000, 32'h7fffffff, 0, 0, MassMax));
    send_item(make_item(OP_ACCUM, 32'h7fffffff, 32'h80000000, 0, 0, MassMax));
    send_item(make_item(OP_MERGE, 0, 0, 32'h80000000, 32'h7fffffff, MassMax));
    send_item(make_item(OP_CLEAR, 32'hffffffff, 32'hffffffff, 32'hffffffff,
                        32'hffffffff, MassMax));
    send_item(make_item(OP_LOAD, 32'h00010000, 32'hffff0000, 32'h00008000, 0, 100));
    send_item(make_item(OP_ACCUM, 32'h00010000, 32'hffff0000, 0, 0, 500));
    send_item(make_item(OP_ACCUM, 32'h00050000, 32'h00030000, 0, 0, 16));
    send_item(make_item(OP_ACCUM, 32'h00010001, 32'hffff0000, 0, 0, 0));
    for (int k = 0; k < 4; k++) send_item(make_item(OP_INTEG, 0, 0, 0, 0, 0));
    send_item(make_item(OP_MERGE, 0, 0, 32'hfff00000, 32'h00200000, 300));
    send_item(make_item(OpSpareFirst, 1, 2, 3, 4, 5));
    send_item(make_item(OpSpareMid, 1, 2, 3, 4, 5));
    send_item(make_item(OpSpareLast, 1, 2, 3, 4, 5));
    send_item(make_item(OP_LOAD, 0, 0, 32'h00010000, 32'hffff0000, 0));
    send_item(make_item(OP_MERGE, 0, 0, 32'h7fffffff, 32'h7fffffff, 0));
  endtask

  // Softening extremes, including zero separation with no softening.
  task automatic test_softening_settings();
    write_softening(32'd0);
    send_item(make_item(OP_LOAD, 32'h00020000, 32'h00020000, 0, 0, 10));
    send_item(make_item(OP_ACCUM, 32'h00020000, 32'h00020000, 0, 0, MassMax));
    send_item(make_item(OP_ACCUM, 32'h00020001, 32'h00020000, 0, 0, MassMax));
    write_softening(32'hffffffff);
    send_item(make_item(OP_ACCUM, 32'h00120000, 32'hfff00000, 0, 0, MassMax));
    send_item(make_item(OP_ACCUM, 32'h80000000, 32'h7fffffff, 0, 0, 1));
    write_softening($urandom);
    for (int k = 0; k < 10; k++) send_item(rand_item());
    write_softening(SoftReset);
  endtask

  // Hold results back long enough that the block stalls its input.
  task automatic test_backpressure();
    wait_results();
    hold_requests++;
    for (int k = 0; k < 6; k++) send_item(rand_item());
    wait_results();
  endtask

  task automatic test_random_mix();
    for (int k = 0; k < RandomItems; k++) begin
      if (k == RandomItems - QuietTail) idle_on = 1'b0;
      if (k % 400 == 399 && idle_on) begin
        case ($urandom_range(0, 2))
          0: write_softening(32'd0);
          1: write_softening($urandom);
          default: write_softening($urandom_range(1, 32'h0010_0000));
        endcase
      end
      if (k % 150 == 0) begin
        send_item(make_item(OP_LOAD, rand_word(), rand_word(), rand_word() >>> 8,
                            rand_word() >>> 8, 24'($urandom_range(1, 1000))));
      end
      send_item(rand_item());
      maybe_gap();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.opcode = '0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_vx = '0;
    in_ch.in_vy = '0;
    in_ch.in_mass = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    idle_on = 1'b1;
    body = '{default: '0};
    soft_sq = SoftReset;
    repeat (8) @(negedge clk);
    rst = 1'b0;

    test_directed_ops();
    test_softening_settings();
    test_backpressure();
    test_random_mix();

    wait_results();
    repeat (DrainCycles) @(negedge clk);
    if (mismatches == 0 && expected_states.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
